>>> src/mssu_pkg.sv
package mssu_pkg;

  // Signature geometry
  localparam int MAX_PATTERN_WORDS = 12;
  localparam int OFFSET_BITS       = 25;
  localparam int HISTORY_DEPTH     = (MAX_PATTERN_WORDS > 1) ? MAX_PATTERN_WORDS - 1 : 1;
  localparam int COUNT_BITS        = OFFSET_BITS - 2;

  // Fixed field widths
  localparam int WORD_BITS  = 32;
  localparam int LEN_BITS   = 4;
  localparam int INDEX_BITS = 4;
  localparam int HITS_BITS  = 2;
  localparam int STAT_BITS  = 2;

  // Stream packing
  localparam int IN_FIELD_W  = INDEX_BITS + 3 * WORD_BITS;
  localparam int IN_TDATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = STAT_BITS + OFFSET_BITS + HITS_BITS;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [LEN_BITS-1:0]   LEN_RESET = LEN_BITS'(12);
  localparam logic [HITS_BITS-1:0]  HITS_SAT  = HITS_BITS'(2);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_SCAN = 1'b1
  } cmd_t;

  typedef enum logic [STAT_BITS-1:0] {
    ST_UNIQUE    = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_AMBIGUOUS = 2'd2
  } status_t;

endpackage

>>> src/masked_signature_unique_search_core.sv
// Channel | Direction | Transfer content
// in_     | slave     | tuser: command; tdata: entry_index, pattern_value,
//         |           |   pattern_mask, data_word (low bit up); tlast: last_word
// out_    | master    | tdata: status, match_offset, hit_count (low bit up)
// cfg_    | write     | pattern_length, taken on any edge with cfg_wen high out of reset
//
// One item per cycle sustained while no held verdict stalls the input. An item
// is held in the input register, where the window compare and counter update
// run, then any verdict is registered in the output register.
// rst_n is synchronous and active low; it clears the scan counters and sets
// pattern_length to twelve. Signature words are undefined until loaded.
// A held verdict stalls only an end-of-region scan item; loads and other scans
// keep flowing past it.
module masked_signature_unique_search_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // in: command
  input  logic                              in_tuser,
  // in: entry_index[3:0], pattern_value[35:4], pattern_mask[67:36],
  //     data_word[99:68], zero fill above
  input  logic [mssu_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                              in_tlast,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // out: status[1:0], match_offset[26:2], hit_count[28:27], zero fill above
  output logic [mssu_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_wen,
  input  logic [mssu_pkg::LEN_BITS-1:0]     cfg_wdata
);
  import mssu_pkg::*;

  // Configuration
  logic [LEN_BITS-1:0] pat_len_r;

  // Input register
  logic                  s1_valid_r;
  logic                  s1_cmd_r;
  logic                  s1_last_r;
  logic [INDEX_BITS-1:0] s1_index_r;
  logic [WORD_BITS-1:0]  s1_value_r;
  logic [WORD_BITS-1:0]  s1_mask_r;
  logic [WORD_BITS-1:0]  s1_data_r;
  logic                  s1_valid_nxt;

  // Signature store and scan state
  logic [WORD_BITS-1:0]   sig_val_r [MAX_PATTERN_WORDS];
  logic [WORD_BITS-1:0]   sig_mask_r [MAX_PATTERN_WORDS];
  logic [WORD_BITS-1:0]   recent_r [HISTORY_DEPTH];
  logic [COUNT_BITS-1:0]  count_r;
  logic [COUNT_BITS-1:0]  count_nxt;
  logic [HITS_BITS-1:0]   hits_r;
  logic [HITS_BITS-1:0]   hits_nxt;
  logic [HITS_BITS-1:0]   hits_upd;
  logic [OFFSET_BITS-1:0] first_off_r;
  logic [OFFSET_BITS-1:0] first_off_nxt;
  logic [OFFSET_BITS-1:0] first_off_upd;

  // Output register
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  status_t                out_status_r;
  status_t                out_status_nxt;
  logic [OFFSET_BITS-1:0] out_off_r;
  logic [OFFSET_BITS-1:0] out_off_nxt;
  logic [HITS_BITS-1:0]   out_hits_r;

  // Work signals
  logic                   is_scan;
  logic                   is_verdict;
  logic                   advance;
  logic                   counting;
  logic                   window_hit;
  logic [LEN_BITS-1:0]    len_eff;
  logic [COUNT_BITS-1:0]  diff;
  logic [WORD_BITS-1:0]   lane_word [MAX_PATTERN_WORDS];
  logic [MAX_PATTERN_WORDS-1:0] lane_ok;

  assign is_scan    = (cmd_t'(s1_cmd_r) == CMD_SCAN);
  assign is_verdict = is_scan && s1_last_r;

  // Advance the input register unless a verdict would land on a held result
  assign advance   = s1_valid_r && (!is_verdict || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign counting  = advance && is_scan && (count_r != COUNT_MAX);

  assign s1_valid_nxt = (in_tvalid && in_tready) ? 1'b1 :
                        (advance ? 1'b0 : s1_valid_r);

  // Saturate the configured length at the store depth
  assign len_eff = (32'(pat_len_r) > MAX_PATTERN_WORDS) ?
                   LEN_BITS'(MAX_PATTERN_WORDS) : pat_len_r;

  // Each lane picks the word that lines up with its signature position:
  // the newest word for the last lane, history for earlier lanes
  always_comb begin
    for (int i = 0; i < MAX_PATTERN_WORDS; i++) begin
      lane_word[i] = s1_data_r;
      for (int j = 0; j < HISTORY_DEPTH; j++) begin
        if (32'(len_eff) == i + j + 2) begin
          lane_word[i] = recent_r[j];
        end
      end
      lane_ok[i] = (i >= 32'(len_eff)) ||
                   (((lane_word[i] ^ sig_val_r[i]) & sig_mask_r[i]) == '0);
    end
  end

  // A window counts only once all its words are in the region
  assign window_hit = (len_eff != '0) &&
                      (count_r >= COUNT_BITS'(len_eff - LEN_BITS'(1))) &&
                      (&lane_ok);

  assign diff = count_r - COUNT_BITS'(len_eff - LEN_BITS'(1));

  always_comb begin
    hits_upd      = hits_r;
    first_off_upd = first_off_r;
    if (counting && window_hit) begin
      if (hits_r == '0) begin
        first_off_upd = {diff, 2'b00};
      end
      if (hits_r != HITS_SAT) begin
        hits_upd = hits_r + HITS_BITS'(1);
      end
    end
  end

  // Verdict, then clear the scan state for the next region
  always_comb begin
    count_nxt     = counting ? count_r + COUNT_BITS'(1) : count_r;
    hits_nxt      = hits_upd;
    first_off_nxt = first_off_upd;
    if (advance && is_verdict) begin
      count_nxt     = '0;
      hits_nxt      = '0;
      first_off_nxt = '0;
    end
  end

  always_comb begin
    out_status_nxt = ST_AMBIGUOUS;
    out_off_nxt    = '0;
    if (hits_upd == HITS_BITS'(1)) begin
      out_status_nxt = ST_UNIQUE;
      out_off_nxt    = first_off_upd;
    end else if (hits_upd == '0) begin
      out_status_nxt = ST_NOT_FOUND;
    end
  end

  assign out_valid_nxt = (advance && is_verdict) || (out_valid_r && !out_tready);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r   <= LEN_RESET;
      s1_valid_r  <= 1'b0;
      count_r     <= '0;
      hits_r      <= '0;
      first_off_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wen) begin
        pat_len_r <= cfg_wdata;
      end
      s1_valid_r  <= s1_valid_nxt;
      if (advance) begin
        count_r     <= count_nxt;
        hits_r      <= hits_nxt;
        first_off_r <= first_off_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_cmd_r   <= in_tuser;
      s1_last_r  <= in_tlast;
      s1_index_r <= in_tdata[INDEX_BITS-1:0];
      s1_value_r <= in_tdata[INDEX_BITS +: WORD_BITS];
      s1_mask_r  <= in_tdata[INDEX_BITS + WORD_BITS +: WORD_BITS];
      s1_data_r  <= in_tdata[INDEX_BITS + 2 * WORD_BITS +: WORD_BITS];
    end
  end

  // Signature load; indexes beyond the store are dropped
  always_ff @(posedge clk) begin
    for (int e = 0; e < MAX_PATTERN_WORDS; e++) begin
      if (advance && !is_scan && (32'(s1_index_r) == e)) begin
        sig_val_r[e]  <= s1_value_r;
        sig_mask_r[e] <= s1_mask_r;
      end
    end
  end

  // History shift, newest first; held once the counter is full
  always_ff @(posedge clk) begin
    if (counting) begin
      recent_r[0] <= s1_data_r;
      for (int j = 1; j < HISTORY_DEPTH; j++) begin
        recent_r[j] <= recent_r[j-1];
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (advance && is_verdict) begin
      out_status_r <= out_status_nxt;
      out_off_r    <= out_off_nxt;
      out_hits_r   <= hits_upd;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_hits_r, out_off_r, out_status_r});

`ifndef SYNTHESIS
  // A unique verdict always carries a count of one
  a_unique_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_status_r == ST_UNIQUE) == (out_hits_r == HITS_BITS'(1))))
    else $error("unique verdict and hit count disagree");

  // Offset is zero unless the hit is unique
  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_UNIQUE) |-> (out_off_r == '0))
    else $error("non-unique verdict carries an offset");

  // Scan state is cleared after every verdict
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && is_verdict) |=> (count_r == '0 && hits_r == '0 && first_off_r == '0))
    else $error("scan state not cleared after verdict");

  // Hit counter never passes saturation
  a_hits_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (hits_r == HITS_SAT && !(advance && is_verdict)) |=> (hits_r == HITS_SAT))
    else $error("hit counter left saturation within a region");
`endif

endmodule
